[hdl/lab_pkg.sv]
// Shared types, constants and saturation helper for the look-at basis pipeline.
package lab_pkg;

  localparam int WIDE_W = 36;
  localparam int UNIT_W = 18;
  localparam int POS_W  = 32;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [POS_W-1:0]  pos_t;

  localparam wide_t UNIT_ONE = 36'sd65536;

  function automatic unit_t sat_unit(input wide_t v);
    unit_t r;
    if (v > UNIT_ONE) begin
      r = 18'sd65536;
    end else if (v < -UNIT_ONE) begin
      r = -18'sd65536;
    end else begin
      r = v[UNIT_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/look_at_basis.sv]
// Top level: look-at basis pipeline (difference, normalise, cross, normalise, cross).
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+------------------------------
//  input   | in_eye_*, in_target_*, in_up_hint_* | taken when start & !busy
//  result  | out_right_*, out_upaxis_*, out_fwd_*,| one-cycle strobe out_valid
//          | out_pos_*                           |
//
// One item per cycle; busy is never raised. The path is the input
// register, two normalisers (32-stage square root and 17-stage divider
// dominate), and two cross product stages after each.
// Synchronous active-low reset clears every valid bit; payload is not reset.
// Results cannot be held off, so nothing in the pipeline ever stalls.
module look_at_basis (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lab_pkg::pos_t   in_eye_x,
  input  lab_pkg::pos_t   in_eye_y,
  input  lab_pkg::pos_t   in_eye_z,
  input  lab_pkg::pos_t   in_target_x,
  input  lab_pkg::pos_t   in_target_y,
  input  lab_pkg::pos_t   in_target_z,
  input  lab_pkg::unit_t  in_up_hint_x,
  input  lab_pkg::unit_t  in_up_hint_y,
  input  lab_pkg::unit_t  in_up_hint_z,
  output logic            out_valid,
  output lab_pkg::unit_t  out_right_x,
  output lab_pkg::unit_t  out_right_y,
  output lab_pkg::unit_t  out_right_z,
  output lab_pkg::unit_t  out_upaxis_x,
  output lab_pkg::unit_t  out_upaxis_y,
  output lab_pkg::unit_t  out_upaxis_z,
  output lab_pkg::unit_t  out_fwd_x,
  output lab_pkg::unit_t  out_fwd_y,
  output lab_pkg::unit_t  out_fwd_z,
  output lab_pkg::pos_t   out_pos_x,
  output lab_pkg::pos_t   out_pos_y,
  output lab_pkg::pos_t   out_pos_z
);
  import lab_pkg::*;

  localparam int PW = 150;

  // input stage
  logic          v0_r;
  wide_t         d_r [3];
  logic [PW-1:0] pay0_r;
  // first normaliser
  logic          na_v;
  unit_t         fwd [3];
  logic [PW-1:0] na_pay;
  unit_t         up [3];
  // up x fwd
  logic          v1_r;
  wide_t         p1_r [6];
  logic [PW-1:0] pay1_r;
  logic          v2_r;
  wide_t         cr_r [3];
  logic [PW-1:0] pay2_r;
  // second normaliser
  logic          nb_v;
  unit_t         right [3];
  logic [PW-1:0] nb_pay;
  unit_t         fwd_b [3];
  // fwd x right
  logic          v3_r;
  wide_t         p3_r [6];
  unit_t         right3_r [3];
  logic [PW-1:0] pay3_r;
  // output
  logic          v4_r;
  unit_t         right_r [3];
  unit_t         ua_r [3];
  unit_t         fwd_r [3];
  pos_t          pos_r [3];

  wide_t         ua_t [3];

  assign busy = 1'b0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up[i]    = na_pay[18*i +: 18];
      fwd_b[i] = nb_pay[18*i +: 18];
    end
  end

  // round half up to Q1.16: arithmetic shift floors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua_t[i] = (p3_r[2*i] - p3_r[2*i+1] + 36'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= na_v;
      v2_r <= v1_r;
      v3_r <= nb_v;
      v4_r <= v3_r;
    end
    d_r[0] <= 36'(in_target_x) - 36'(in_eye_x);
    d_r[1] <= 36'(in_target_y) - 36'(in_eye_y);
    d_r[2] <= 36'(in_target_z) - 36'(in_eye_z);
    pay0_r <= {in_eye_z, in_eye_y, in_eye_x, in_up_hint_z, in_up_hint_y, in_up_hint_x};

    p1_r[0] <= 36'(up[1]) * 36'(fwd[2]);
    p1_r[1] <= 36'(up[2]) * 36'(fwd[1]);
    p1_r[2] <= 36'(up[2]) * 36'(fwd[0]);
    p1_r[3] <= 36'(up[0]) * 36'(fwd[2]);
    p1_r[4] <= 36'(up[0]) * 36'(fwd[1]);
    p1_r[5] <= 36'(up[1]) * 36'(fwd[0]);
    pay1_r  <= {na_pay[PW-1 -: 96], fwd[2], fwd[1], fwd[0]};
    for (int i = 0; i < 3; i++) begin
      cr_r[i] <= p1_r[2*i] - p1_r[2*i+1];
    end
    pay2_r <= pay1_r;

    p3_r[0] <= 36'(fwd_b[1]) * 36'(right[2]);
    p3_r[1] <= 36'(fwd_b[2]) * 36'(right[1]);
    p3_r[2] <= 36'(fwd_b[2]) * 36'(right[0]);
    p3_r[3] <= 36'(fwd_b[0]) * 36'(right[2]);
    p3_r[4] <= 36'(fwd_b[0]) * 36'(right[1]);
    p3_r[5] <= 36'(fwd_b[1]) * 36'(right[0]);
    right3_r <= right;
    pay3_r   <= nb_pay;
    for (int i = 0; i < 3; i++) begin
      right_r[i] <= right3_r[i];
      ua_r[i]    <= sat_unit(ua_t[i]);
      fwd_r[i]   <= pay3_r[18*i +: 18];
      pos_r[i]   <= pay3_r[54 + 32*i +: 32];
    end
  end

  lab_norm #(.PW(PW)) u_norm_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v0_r),
    .s_vec   (d_r),
    .s_pay   (pay0_r),
    .m_valid (na_v),
    .m_vec   (fwd),
    .m_pay   (na_pay)
  );

  lab_norm #(.PW(PW)) u_norm_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v2_r),
    .s_vec   (cr_r),
    .s_pay   (pay2_r),
    .m_valid (nb_v),
    .m_vec   (right),
    .m_pay   (nb_pay)
  );

  assign out_valid    = v4_r;
  assign out_right_x  = right_r[0];
  assign out_right_y  = right_r[1];
  assign out_right_z  = right_r[2];
  assign out_upaxis_x = ua_r[0];
  assign out_upaxis_y = ua_r[1];
  assign out_upaxis_z = ua_r[2];
  assign out_fwd_x    = fwd_r[0];
  assign out_fwd_y    = fwd_r[1];
  assign out_fwd_z    = fwd_r[2];
  assign out_pos_x    = pos_r[0];
  assign out_pos_y    = pos_r[1];
  assign out_pos_z    = pos_r[2];

  a_reset_flush: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result strobe straight after reset");

  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fwd_x <= 18'sd65536 && out_fwd_x >= -18'sd65536 &&
                   out_fwd_y <= 18'sd65536 && out_fwd_y >= -18'sd65536 &&
                   out_fwd_z <= 18'sd65536 && out_fwd_z >= -18'sd65536))
    else $error("forward axis out of unit range");

  a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fwd_x == '0 && out_fwd_y == '0 && out_fwd_z == '0) |->
    (out_right_x == '0 && out_right_y == '0 && out_right_z == '0))
    else $error("right axis set with zero forward axis");

  a_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_right_x == '0 && out_right_y == '0 && out_right_z == '0) |->
    (out_upaxis_x == '0 && out_upaxis_y == '0 && out_upaxis_z == '0))
    else $error("up axis set with zero right axis");

endmodule

[hdl/lab_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with side data.
module lab_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  input  logic [63:0]   s_n,
  input  logic [SW-1:0] s_side,
  output logic          m_valid,
  output logic [31:0]   m_root,
  output logic [SW-1:0] m_side
);
  localparam int STG = 32;

  logic          v_r    [STG];
  logic [63:0]   n_r    [STG];
  logic [33:0]   rem_r  [STG];
  logic [31:0]   root_r [STG];
  logic [SW-1:0] side_r [STG];

  for (genvar i = 0; i < STG; i++) begin : g_stg
    logic          v_p;
    logic [63:0]   n_p;
    logic [33:0]   rem_p;
    logic [31:0]   root_p;
    logic [SW-1:0] side_p;
    logic [35:0]   acc;
    logic [35:0]   trial;
    logic [33:0]   rem_nxt;
    logic [31:0]   root_nxt;

    if (i == 0) begin : g_first
      assign v_p    = s_valid;
      assign n_p    = s_n;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = s_side;
    end else begin : g_next
      assign v_p    = v_r[i-1];
      assign n_p    = n_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign side_p = side_r[i-1];
    end

    always_comb begin
      acc   = {rem_p, n_p[63-2*i -: 2]};
      trial = {root_p, 2'b01};
      if (acc >= trial) begin
        rem_nxt  = 34'(acc - trial);
        root_nxt = {root_p[30:0], 1'b1};
      end else begin
        rem_nxt  = acc[33:0];
        root_nxt = {root_p[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_p;
      end
      n_r[i]    <= n_p;
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      side_r[i] <= side_p;
    end
  end

  assign m_valid = v_r[STG-1];
  assign m_root  = root_r[STG-1];
  assign m_side  = side_r[STG-1];

endmodule

[hdl/lab_div.sv]
// Pipelined restoring divider, three numerators over one divisor, 17 quotient bits.
module lab_div #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  input  logic [47:0]   s_num [3],
  input  logic [31:0]   s_den,
  input  logic [SW-1:0] s_side,
  output logic          m_valid,
  output logic [16:0]   m_quo [3],
  output logic [SW-1:0] m_side
);
  localparam int STG = 17;

  logic          v_r    [STG];
  logic [31:0]   den_r  [STG];
  logic [47:0]   rem_r  [STG][3];
  logic [16:0]   quo_r  [STG][3];
  logic [SW-1:0] side_r [STG];

  for (genvar i = 0; i < STG; i++) begin : g_stg
    logic          v_p;
    logic [31:0]   den_p;
    logic [47:0]   rem_p [3];
    logic [16:0]   quo_p [3];
    logic [SW-1:0] side_p;
    logic [47:0]   dsh;
    logic [47:0]   rem_nxt [3];
    logic [16:0]   quo_nxt [3];

    if (i == 0) begin : g_first
      assign v_p    = s_valid;
      assign den_p  = s_den;
      assign side_p = s_side;
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_p[l] = s_num[l];
        assign quo_p[l] = '0;
      end
    end else begin : g_next
      assign v_p    = v_r[i-1];
      assign den_p  = den_r[i-1];
      assign side_p = side_r[i-1];
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_p[l] = rem_r[i-1][l];
        assign quo_p[l] = quo_r[i-1][l];
      end
    end

    always_comb begin
      dsh = 48'(den_p) << (STG - 1 - i);
      for (int l = 0; l < 3; l++) begin
        quo_nxt[l] = quo_p[l];
        if (rem_p[l] >= dsh) begin
          rem_nxt[l]              = rem_p[l] - dsh;
          quo_nxt[l][STG - 1 - i] = 1'b1;
        end else begin
          rem_nxt[l] = rem_p[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_p;
      end
      den_r[i]  <= den_p;
      side_r[i] <= side_p;
      for (int l = 0; l < 3; l++) begin
        rem_r[i][l] <= rem_nxt[l];
        quo_r[i][l] <= quo_nxt[l];
      end
    end
  end

  assign m_valid = v_r[STG-1];
  assign m_side  = side_r[STG-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign m_quo[l] = quo_r[STG-1][l];
  end

endmodule

[hdl/lab_norm.sv]
// Vector normaliser: prescale, squares, sum, square root, divide, sign and saturate.
module lab_norm #(
  parameter int PW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  input  lab_pkg::wide_t       s_vec [3],
  input  logic [PW-1:0]        s_pay,
  output logic                 m_valid,
  output lab_pkg::unit_t       m_vec [3],
  output logic [PW-1:0]        m_pay
);
  import lab_pkg::*;

  localparam int SQ_SW  = PW + 3 + 93;
  localparam int DIV_SW = PW + 4;

  // magnitudes
  logic          v1_r;
  logic [35:0]   mag_r [3];
  logic [2:0]    neg1_r;
  logic [PW-1:0] pay1_r;
  // prescaled
  logic          v2_r;
  logic [30:0]   m2_r [3];
  logic [2:0]    neg2_r;
  logic [PW-1:0] pay2_r;
  // squares
  logic          v3_r;
  logic [61:0]   sq_r [3];
  logic [30:0]   m3_r [3];
  logic [2:0]    neg3_r;
  logic [PW-1:0] pay3_r;
  // sum
  logic          v4_r;
  logic [63:0]   sum_r;
  logic [30:0]   m4_r [3];
  logic [2:0]    neg4_r;
  logic [PW-1:0] pay4_r;
  // after root
  logic          sq_v;
  logic [31:0]   sq_root;
  logic [SQ_SW-1:0] sq_side;
  // numerators
  logic          v5_r;
  logic [47:0]   num_r [3];
  logic [31:0]   den_r;
  logic [DIV_SW-1:0] dside_r;
  // divider out
  logic          dv;
  logic [16:0]   quo [3];
  logic [DIV_SW-1:0] dside;
  // output
  logic          v6_r;
  unit_t         vec_r [3];
  logic [PW-1:0] pay6_r;

  logic [35:0]   mag_nxt [3];
  logic [35:0]   mx;
  logic [2:0]    sh;
  logic [30:0]   m_sq [3];
  unit_t         vec_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = s_vec[i][35] ? 36'(-s_vec[i]) : 36'(s_vec[i]);
    end
  end

  // smallest right shift that brings the largest magnitude below 2^31
  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    sh = 3'd5;
    for (int s = 5; s >= 0; s--) begin
      if ((mx >> s) < 36'd2147483648) sh = 3'(s);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_sq[i] = sq_side[31*i +: 31];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dside[3]) begin
        vec_nxt[i] = '0;
      end else if (dside[i]) begin
        vec_nxt[i] = sat_unit(-$signed({19'b0, quo[i]}));
      end else begin
        vec_nxt[i] = sat_unit($signed({19'b0, quo[i]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= s_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= sq_v;
      v6_r <= dv;
    end
    for (int i = 0; i < 3; i++) begin
      mag_r[i]  <= mag_nxt[i];
      neg1_r[i] <= s_vec[i][35];
      m2_r[i]   <= 31'(mag_r[i] >> sh);
      sq_r[i]   <= 62'(m2_r[i]) * 62'(m2_r[i]);
      m3_r[i]   <= m2_r[i];
      m4_r[i]   <= m3_r[i];
      num_r[i]  <= {1'b0, m_sq[i], 16'b0} + 48'(sq_root >> 1);
      vec_r[i]  <= vec_nxt[i];
    end
    pay1_r  <= s_pay;
    neg2_r  <= neg1_r;
    pay2_r  <= pay1_r;
    neg3_r  <= neg2_r;
    pay3_r  <= pay2_r;
    sum_r   <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    neg4_r  <= neg3_r;
    pay4_r  <= pay3_r;
    den_r   <= sq_root;
    // zero length vector: root is zero
    dside_r <= {sq_side[SQ_SW-1 -: PW], (sq_root == 32'd0), sq_side[93 +: 3]};
    pay6_r  <= dside[DIV_SW-1 -: PW];
  end

  lab_sqrt #(.SW(SQ_SW)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v4_r),
    .s_n     (sum_r),
    .s_side  ({pay4_r, neg4_r, m4_r[2], m4_r[1], m4_r[0]}),
    .m_valid (sq_v),
    .m_root  (sq_root),
    .m_side  (sq_side)
  );

  lab_div #(.SW(DIV_SW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v5_r),
    .s_num   (num_r),
    .s_den   (den_r),
    .s_side  (dside_r),
    .m_valid (dv),
    .m_quo   (quo),
    .m_side  (dside)
  );

  assign m_valid = v6_r;
  assign m_vec   = vec_r;
  assign m_pay   = pay6_r;

endmodule

[test/testbench.sv]
// Self-checking testbench for the look-at basis pipeline: queued stimulus, in-line predictor.
module testbench;
  import lab_pkg::*;

  typedef struct {
    pos_t  eye[3];
    pos_t  tgt[3];
    unit_t up[3];
    bit    drain_first;
  } view_item_t;

  typedef struct {
    unit_t rgt[3];
    unit_t ua[3];
    unit_t fwd[3];
    pos_t  pos[3];
  } basis_t;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 150;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  pos_t  drv_eye[3] = '{default: '0};
  pos_t  drv_tgt[3] = '{default: '0};
  unit_t drv_up[3] = '{default: '0};
  logic  out_valid;
  unit_t got_rgt[3], got_ua[3], got_fwd[3];
  pos_t  got_pos[3];

  view_item_t pending[$];
  basis_t     basis_due[$];
  int         errors = 0;
  int         gap_left = 0;
  bit         burst = 1'b0;
  int         stall_cycles = 0;

  look_at_basis u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_eye_x(drv_eye[0]), .in_eye_y(drv_eye[1]), .in_eye_z(drv_eye[2]),
    .in_target_x(drv_tgt[0]), .in_target_y(drv_tgt[1]), .in_target_z(drv_tgt[2]),
    .in_up_hint_x(drv_up[0]), .in_up_hint_y(drv_up[1]), .in_up_hint_z(drv_up[2]),
    .out_valid(out_valid),
    .out_right_x(got_rgt[0]), .out_right_y(got_rgt[1]), .out_right_z(got_rgt[2]),
    .out_upaxis_x(got_ua[0]), .out_upaxis_y(got_ua[1]), .out_upaxis_z(got_ua[2]),
    .out_fwd_x(got_fwd[0]), .out_fwd_y(got_fwd[1]), .out_fwd_z(got_fwd[2]),
    .out_pos_x(got_pos[0]), .out_pos_y(got_pos[1]), .out_pos_z(got_pos[2])
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_unit(input longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Unit vector: magnitudes pre-shifted below 2^31, rounded half away from zero.
  function automatic void to_unit(input longint a, input longint b, input longint c,
                                  output longint oa, output longint ob, output longint oc);
    longint          v[3];
    longint          o[3];
    longint unsigned m[3];
    longint unsigned mx, sum, len, q;
    int              sh;
    v[0] = a; v[1] = b; v[2] = c;
    mx = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    while (sh < 63 && (mx >> sh) >= (64'd1 << 31)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> sh;
      sum += m[i] * m[i];
    end
    if (sum == 0) begin
      o = '{0, 0, 0};
    end else begin
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 64'd65536 + len / 2) / len;
        o[i] = clamp_unit(v[i] < 0 ? -longint'(q) : longint'(q));
      end
    end
    oa = o[0]; ob = o[1]; oc = o[2];
  endfunction

  function automatic basis_t look_at_predict(input view_item_t it);
    basis_t r;
    longint d[3], f[3], u[3], cr[3], rg[3], ua;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(it.tgt[i]) - longint'(it.eye[i]);
      u[i] = longint'(it.up[i]);
    end
    to_unit(d[0], d[1], d[2], f[0], f[1], f[2]);
    cr[0] = u[1] * f[2] - u[2] * f[1];
    cr[1] = u[2] * f[0] - u[0] * f[2];
    cr[2] = u[0] * f[1] - u[1] * f[0];
    to_unit(cr[0], cr[1], cr[2], rg[0], rg[1], rg[2]);
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: ua = f[1] * rg[2] - f[2] * rg[1];
        1: ua = f[2] * rg[0] - f[0] * rg[2];
        default: ua = f[0] * rg[1] - f[1] * rg[0];
      endcase
      // round half up to Q1.16 (floor of the biased value)
      ua = (ua + 32768) >>> 16;
      r.ua[i]  = unit_t'(clamp_unit(ua));
      r.rgt[i] = unit_t'(rg[i]);
      r.fwd[i] = unit_t'(f[i]);
      r.pos[i] = it.eye[i];
    end
    return r;
  endfunction

  function automatic view_item_t make_view(input longint ex, input longint ey, input longint ez,
                                           input longint tx, input longint ty, input longint tz,
                                           input int ux, input int uy, input int uz);
    view_item_t it;
    it.eye = '{pos_t'(ex), pos_t'(ey), pos_t'(ez)};
    it.tgt = '{pos_t'(tx), pos_t'(ty), pos_t'(tz)};
    it.up  = '{unit_t'(ux), unit_t'(uy), unit_t'(uz)};
    it.drain_first = 1'b0;
    return it;
  endfunction

  function automatic view_item_t random_view();
    view_item_t it;
    int         mode, umode, k;
    int         dlt[3];
    mode = $urandom_range(0, 9);
    umode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      it.eye[i] = $urandom;
      dlt[i] = $signed($urandom_range(0, 400)) - 200;
      if (mode < 4) it.tgt[i] = $urandom;
      else if (mode < 7) it.tgt[i] = it.eye[i] + pos_t'($signed(16'($urandom)));
      else if (mode < 9) it.tgt[i] = it.eye[i] + pos_t'(dlt[i]);
      else it.tgt[i] = it.eye[i];
      if (umode < 6) it.up[i] = unit_t'($signed($urandom_range(0, 131072)) - 65536);
      else if (umode < 8) it.up[i] = unit_t'($urandom);
      else it.up[i] = '0;
    end
    // up hint along the view direction
    if (umode == 9 && mode >= 7) begin
      k = $signed($urandom_range(0, 200)) - 100;
      for (int i = 0; i < 3; i++) it.up[i] = unit_t'(dlt[i] * k);
    end
    it.drain_first = 1'b0;
    return it;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: one item per accept, random gaps, bursts with no gap.
  always @(posedge clk) begin
    logic       nxt_start;
    view_item_t cur;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur.eye = drv_eye;
        cur.tgt = drv_tgt;
        cur.up = drv_up;
        basis_due.push_back(look_at_predict(cur));
      end
      nxt_start = start && busy;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain_first && basis_due.size() > 0)) begin
          cur = pending.pop_front();
          drv_eye <= cur.eye;
          drv_tgt <= cur.tgt;
          drv_up <= cur.up;
          nxt_start = 1'b1;
          if ($urandom_range(0, 39) == 0) burst = !burst;
          gap_left = burst ? 0 : $urandom_range(0, 3);
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor: compare each strobed result against the oldest expected basis.
  always @(posedge clk) begin
    basis_t e;
    if (rst_n && out_valid) begin
      if (basis_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result, expected none actual right_x %0d",
                 $time, got_rgt[0]);
      end else begin
        e = basis_due.pop_front();
        for (int i = 0; i < 3; i++) begin
          check_field($sformatf("right[%0d]", i), e.rgt[i], got_rgt[i]);
          check_field($sformatf("upaxis[%0d]", i), e.ua[i], got_ua[i]);
          check_field($sformatf("fwd[%0d]", i), e.fwd[i], got_fwd[i]);
          check_field($sformatf("pos[%0d]", i), e.pos[i], got_pos[i]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    view_item_t it;
    // extremes, zero vectors, parallel and out-of-range up hints
    pending.push_back(make_view(-2147483648, -2147483648, -2147483648,
                                2147483647, 2147483647, 2147483647, 0, 65536, 0));
    pending.push_back(make_view(2147483647, -2147483648, 0,
                                -2147483648, 2147483647, 0, 0, 0, 65536));
    pending.push_back(make_view(0, 0, 0, 0, 0, 65536, 0, 65536, 0));
    pending.push_back(make_view(0, 0, 0, 65536, 0, 0, 0, -65536, 0));
    pending.push_back(make_view(100, 200, 300, 100, 200, 300, 0, 65536, 0));
    pending.push_back(make_view(0, 0, 0, 0, 65536, 0, 0, 65536, 0));
    pending.push_back(make_view(0, 0, 0, 0, 0, 65536, 0, 0, 0));
    pending.push_back(make_view(0, 0, 0, 3, 4, 5, 6, 8, 10));
    pending.push_back(make_view(0, 0, 0, 1, 0, 0, -131072, 131071, -1));
    pending.push_back(make_view(0, 0, 0, 1, 1, 1, 131071, 131071, -131072));
    pending.push_back(make_view(-1, -1, -1, 0, 0, 0, -65536, -65536, -65536));
    pending.push_back(make_view(0, 0, 0, 1, 2, 3, 65536, 65536, 65536));
    pending.push_back(make_view(2147483647, 2147483647, 2147483647,
                                -2147483648, 2147483647, 2147483647, 0, 1, 0));
    pending.push_back(make_view(0, 0, 0, 7, -3, 2, 1, -1, 1));
    pending.push_back(make_view(-2147483648, 0, 0, 2147483647, 1, 0, 0, 0, -1));
    for (int n = 0; n < 900; n++) begin
      it = random_view();
      if (n == 450) it.drain_first = 1'b1;
      pending.push_back(it);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() > 0 || start || basis_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lab_pkg.sv
hdl/lab_sqrt.sv
hdl/lab_div.sv
hdl/lab_norm.sv
hdl/look_at_basis.sv
test/testbench.sv
